[src/anc_pkg.sv]
// Shared types and constants for the anchor box generator.
// Used by anc_arith, anchor_box_generator and anc_checker; no dependencies.
package anc_pkg;

    localparam int MAX_LOADED_RATIOS = 8;
    localparam int MAX_FMAP          = 1024;
    localparam int RATIO_DEPTH       = 1 + 2 * MAX_LOADED_RATIOS;
    localparam int CNT_W             = $clog2(RATIO_DEPTH + 1);
    localparam int RAM_AW            = $clog2(RATIO_DEPTH - 1);
    localparam int FMAP_W            = 11;

    localparam int NUM_W  = 64;
    localparam int DEN_W  = 36;
    localparam int ROOT_W = 32;
    localparam int STEP_W = 7;

    localparam logic [23:0] ONE_Q16 = 24'h010000;
    localparam logic [FMAP_W-1:0] FMAP_LIMIT = FMAP_W'(MAX_FMAP);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_GEN   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_BAD_RATIO = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_FMAP_W  = 3'd0,
        CFG_FMAP_H  = 3'd1,
        CFG_STEP_X  = 3'd2,
        CFG_STEP_Y  = 3'd3,
        CFG_OFFSET  = 3'd4,
        CFG_FLIP    = 3'd5,
        CFG_CLIP    = 3'd6,
        CFG_UNUSED  = 3'd7
    } cfg_idx_t;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_LSCAN = 17'h00002,
        S_LCHK  = 17'h00004,
        S_LREC  = 17'h00008,
        S_GSCAN = 17'h00010,
        S_GPREP = 17'h00020,
        S_BOX   = 17'h00040,
        S_BMAX  = 17'h00080,
        S_BRW   = 17'h00100,
        S_BRD   = 17'h00200,
        S_BRH   = 17'h00400,
        S_CSET  = 17'h00800,
        S_CFIN  = 17'h01000,
        S_EMIT  = 17'h02000,
        S_KICK  = 17'h04000,
        S_WAIT  = 17'h08000,
        S_SPARE = 17'h10000
    } state_t;

    typedef struct packed {
        logic go;
        logic sqrt;
    } arith_cmd_t;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } arith_stat_t;

endpackage

[src/anchor_box_generator.sv]
// A load scans the list and, with flip on, also stores a reciprocal from the shared unit.
// A generate scans the list, then each box takes four 64-step divisions (one per
// corner), a max box one root more and a ratio box two roots and a division more,
// all in the one shared divide / root unit.
// One word is in work at a time; in_stall is high until its last result is queued.
// Reset is asynchronous: control and config registers return to defaults, the list to {1.0}.
module anchor_box_generator import anc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [23:0] ratio_value,
    input  logic [9:0]         cell_row,
    input  logic [9:0]         cell_col,
    input  logic [15:0]        min_box,
    input  logic [15:0]        max_box,
    input  logic               has_max,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [20:0] x_low,
    output logic signed [20:0] y_low,
    output logic signed [20:0] x_high,
    output logic signed [20:0] y_high,
    output logic [1:0]         status,
    output logic               last
);

    // Configuration registers
    logic [FMAP_W-1:0] fmap_w_reg, fmap_h_reg;
    logic [23:0]       step_x_reg, step_y_reg;
    logic [15:0]       coff_reg;
    logic              flip_reg, clip_reg;
    logic [FMAP_W-1:0] fw_eff, fh_eff;
    logic [23:0]       sx_eff, sy_eff;

    // Control state
    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic [CNT_W-1:0]  nonone_reg, nonone_next;
    logic [CNT_W-1:0]  nbox_reg, nbox_next;
    logic [1:0]        ci_reg, ci_next;
    logic              single_reg, single_next;
    logic              out_valid_reg, out_valid_next;
    logic              a_sqrt_reg, a_sqrt_next;

    // Payload
    logic [23:0]       raw_reg, raw_next;
    logic [9:0]        row_reg, row_next, col_reg, col_next;
    logic [15:0]       mn_reg, mn_next, mx_reg, mx_next;
    logic              hm_reg, hm_next;
    logic [1:0]        stat_reg, stat_next;
    logic              neg_reg, neg_next;
    logic [ROOT_W-1:0] bw_reg, bw_next, bh_reg, bh_next;
    logic [49:0]       csx_reg, csx_next, csy_reg, csy_next;
    logic [34:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [31:0]       m2_reg, m2_next;
    logic [NUM_W-1:0]  a_num_reg, a_num_next;
    logic [DEN_W-1:0]  a_den_reg, a_den_next;
    logic [20:0]       crd_reg [4];
    logic [20:0]       crd_next [4];
    logic [20:0]       xl_reg, xl_next, yl_reg, yl_next;
    logic [20:0]       xh_reg, xh_next, yh_reg, yh_next;
    logic [1:0]        ost_reg, ost_next;
    logic              olast_reg, olast_next;

    // Ratio store: entry zero is always 1.0, the rest live here.
    logic [23:0]       ratio_mem_reg [RATIO_DEPTH-1];
    logic              mem_we;
    logic [RAM_AW-1:0] mem_wa;
    logic [23:0]       mem_wd;
    logic [CNT_W-1:0]  km1, cm1;
    logic [23:0]       rd_entry;

    // Shared unit
    arith_cmd_t        a_cmd;
    arith_stat_t       a_stat;
    logic [NUM_W-1:0]  a_quo;
    logic [ROOT_W-1:0] a_root;

    // Coordinate datapath
    logic [49:0]        cs_sel;
    logic [34:0]        d_sel;
    logic [ROOT_W-1:0]  b_sel;
    logic signed [55:0] cs_s, b_s, d_s, n_s, t_s, mag_s;
    logic [64:0]        qq;
    logic signed [21:0] v_s;
    logic [23:0]        abs_raw;
    logic [23:0]        rec_val;
    logic               can_load, last_now;
    logic [CNT_W:0]     need_sum;
    logic               entry_nonone, entry_bad;
    logic [31:0]        mm_prod;
    logic [55:0]        mr_prod;

    anc_arith u_arith
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (a_cmd),
        .num    (a_num_reg),
        .den    (a_den_reg),
        .stat   (a_stat),
        .quo    (a_quo),
        .root   (a_root)
    );

    always_comb
    begin
        fw_eff = (fmap_w_reg == '0) ? FMAP_W'(1) :
                 (fmap_w_reg > FMAP_LIMIT) ? FMAP_LIMIT : fmap_w_reg;
        fh_eff = (fmap_h_reg == '0) ? FMAP_W'(1) :
                 (fmap_h_reg > FMAP_LIMIT) ? FMAP_LIMIT : fmap_h_reg;
        sx_eff = (step_x_reg == '0) ? 24'd1 : step_x_reg;
        sy_eff = (step_y_reg == '0) ? 24'd1 : step_y_reg;
    end

    assign km1      = k_reg - CNT_W'(1);
    assign cm1      = cnt_reg - CNT_W'(1);
    assign rd_entry = (k_reg == '0) ? ONE_Q16 : ratio_mem_reg[km1[RAM_AW-1:0]];
    assign entry_nonone = rd_entry != ONE_Q16;
    assign entry_bad    = entry_nonone && (rd_entry[23] || rd_entry == '0);

    assign a_cmd.go   = state_reg == S_KICK;
    assign a_cmd.sqrt = a_sqrt_reg;

    assign can_load = !out_valid_reg || !out_stall;
    assign last_now = single_reg || ((e_reg + CNT_W'(1)) == nbox_reg);
    assign need_sum = {1'b0, cnt_reg} + (flip_reg ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign abs_raw  = raw_reg[23] ? (24'd0 - raw_reg) : raw_reg;
    assign mm_prod  = mn_reg * mx_reg;
    assign mr_prod  = m2_reg * rd_entry;

    // One corner: n / d rounded half up, as floor((2n + d) / 2d), with n = C*S -/+ B*2^11.
    always_comb
    begin
        cs_sel = ci_reg[0] ? csy_reg : csx_reg;
        d_sel  = ci_reg[0] ? dy_reg : dx_reg;
        b_sel  = ci_reg[0] ? bh_reg : bw_reg;
        cs_s   = $signed({6'd0, cs_sel});
        b_s    = $signed({13'd0, b_sel, 11'd0});
        d_s    = $signed({21'd0, d_sel});
        n_s    = ci_reg[1] ? (cs_s + b_s) : (cs_s - b_s);
        t_s    = (n_s <<< 1) + d_s;
        mag_s  = t_s[55] ? -t_s : t_s;

        qq = {1'b0, a_quo} + {64'd0, a_stat.rem_nz};
        if (!neg_reg)
        begin
            v_s = (a_quo > 64'd1048575) ? 22'sd1048575 : $signed({1'b0, a_quo[20:0]});
        end
        else
        begin
            v_s = (qq > 65'd1048576) ? -22'sd1048576 : -$signed({1'b0, qq[20:0]});
        end
        if (clip_reg && v_s < 22'sd0)
        begin
            v_s = 22'sd0;
        end
        if (clip_reg && v_s > 22'sd65536)
        begin
            v_s = 22'sd65536;
        end

        if (!raw_reg[23])
        begin
            rec_val = (a_quo > 64'd8388607) ? 24'h7FFFFF : a_quo[23:0];
        end
        else
        begin
            rec_val = (a_quo > 64'd8388608) ? 24'h800000 : (24'd0 - a_quo[23:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        nonone_next    = nonone_reg;
        nbox_next      = nbox_reg;
        ci_next        = ci_reg;
        single_next    = single_reg;
        a_sqrt_next    = a_sqrt_reg;
        raw_next       = raw_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        hm_next        = hm_reg;
        stat_next      = stat_reg;
        neg_next       = neg_reg;
        bw_next        = bw_reg;
        bh_next        = bh_reg;
        csx_next       = csx_reg;
        csy_next       = csy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        m2_next        = m2_reg;
        a_num_next     = a_num_reg;
        a_den_next     = a_den_reg;
        crd_next       = crd_reg;
        xl_next        = xl_reg;
        yl_next        = yl_reg;
        xh_next        = xh_reg;
        yh_next        = yh_reg;
        ost_next       = ost_reg;
        olast_next     = olast_reg;
        mem_we         = 1'b0;
        mem_wa         = cm1[RAM_AW-1:0];
        mem_wd         = raw_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next    = ratio_value;
                    row_next    = cell_row;
                    col_next    = cell_col;
                    mn_next     = min_box;
                    mx_next     = max_box;
                    hm_next     = has_max;
                    k_next      = '0;
                    nonone_next = '0;
                    single_next = 1'b1;
                    case (op_t'(op))
                        OP_LOAD:
                        begin
                            state_next = S_LSCAN;
                        end
                        OP_GEN:
                        begin
                            if (has_max && (min_box == '0 || max_box == '0))
                            begin
                                stat_next  = ST_BAD_SIZE;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                single_next = 1'b0;
                                state_next  = S_GSCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = CNT_W'(1);
                            stat_next  = ST_OK;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LSCAN:
            begin
                if (rd_entry == raw_reg)
                begin
                    stat_next  = ST_OK;
                    state_next = S_EMIT;
                end
                else if ((k_reg + CNT_W'(1)) == cnt_reg)
                begin
                    state_next = S_LCHK;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            S_LCHK:
            begin
                if (flip_reg && raw_reg == '0)
                begin
                    stat_next  = ST_BAD_RATIO;
                    state_next = S_EMIT;
                end
                else if (need_sum > (CNT_W+1)'(RATIO_DEPTH))
                begin
                    stat_next  = ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_we    = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    stat_next = ST_OK;
                    if (flip_reg)
                    begin
                        // Reciprocal rounded half up: (2^33 + a) / 2a.
                        a_num_next  = (NUM_W'(1) << 33) + NUM_W'(abs_raw);
                        a_den_next  = DEN_W'({abs_raw, 1'b0});
                        a_sqrt_next = 1'b0;
                        ret_next    = S_LREC;
                        state_next  = S_KICK;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_LREC:
            begin
                mem_we     = 1'b1;
                mem_wd     = rec_val;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_EMIT;
            end
            S_GSCAN:
            begin
                if (entry_bad)
                begin
                    single_next = 1'b1;
                    stat_next   = ST_BAD_RATIO;
                    state_next  = S_EMIT;
                end
                else
                begin
                    nonone_next = nonone_reg + CNT_W'(entry_nonone);
                    if ((k_reg + CNT_W'(1)) == cnt_reg)
                    begin
                        state_next = S_GPREP;
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            S_GPREP:
            begin
                csx_next   = {col_reg, coff_reg} * sx_eff;
                csy_next   = {row_reg, coff_reg} * sy_eff;
                dx_next    = sx_eff * fw_eff;
                dy_next    = sy_eff * fh_eff;
                m2_next    = mn_reg * mn_reg;
                nbox_next  = nonone_reg + CNT_W'(hm_reg) + CNT_W'(1);
                k_next     = '0;
                e_next     = '0;
                stat_next  = ST_OK;
                state_next = S_BOX;
            end
            S_BOX:
            begin
                ci_next     = '0;
                a_sqrt_next = 1'b1;
                if (e_reg == '0)
                begin
                    bw_next    = ROOT_W'({mn_reg, 8'd0});
                    bh_next    = ROOT_W'({mn_reg, 8'd0});
                    state_next = S_CSET;
                end
                else if (e_reg == CNT_W'(1) && hm_reg)
                begin
                    a_num_next = NUM_W'({mm_prod, 16'd0});
                    ret_next   = S_BMAX;
                    state_next = S_KICK;
                end
                else if (!entry_nonone)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    a_num_next = NUM_W'(mr_prod);
                    ret_next   = S_BRW;
                    state_next = S_KICK;
                end
            end
            S_BMAX:
            begin
                bw_next    = a_root;
                bh_next    = a_root;
                state_next = S_CSET;
            end
            S_BRW:
            begin
                bw_next     = a_root;
                a_num_next  = {m2_reg, 32'd0};
                a_den_next  = DEN_W'(rd_entry);
                a_sqrt_next = 1'b0;
                ret_next    = S_BRD;
                state_next  = S_KICK;
            end
            S_BRD:
            begin
                a_num_next  = a_quo;
                a_sqrt_next = 1'b1;
                ret_next    = S_BRH;
                state_next  = S_KICK;
            end
            S_BRH:
            begin
                bh_next    = a_root;
                k_next     = k_reg + CNT_W'(1);
                state_next = S_CSET;
            end
            S_CSET:
            begin
                neg_next    = t_s[55];
                a_num_next  = {8'd0, mag_s};
                a_den_next  = {d_sel, 1'b0};
                a_sqrt_next = 1'b0;
                ret_next    = S_CFIN;
                state_next  = S_KICK;
            end
            S_CFIN:
            begin
                crd_next[ci_reg] = v_s[20:0];
                ci_next          = ci_reg + 2'd1;
                state_next       = (ci_reg == 2'd3) ? S_EMIT : S_CSET;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    xl_next        = single_reg ? '0 : crd_reg[0];
                    yl_next        = single_reg ? '0 : crd_reg[1];
                    xh_next        = single_reg ? '0 : crd_reg[2];
                    yh_next        = single_reg ? '0 : crd_reg[3];
                    ost_next       = stat_reg;
                    olast_next     = last_now;
                    e_next         = e_reg + CNT_W'(1);
                    state_next     = last_now ? S_IDLE : S_BOX;
                end
            end
            S_KICK:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (a_stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmap_w_reg <= FMAP_W'(1);
            fmap_h_reg <= FMAP_W'(1);
            step_x_reg <= 24'd256;
            step_y_reg <= 24'd256;
            coff_reg   <= 16'd32768;
            flip_reg   <= 1'b0;
            clip_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FMAP_W: fmap_w_reg <= cfg_data[FMAP_W-1:0];
                CFG_FMAP_H: fmap_h_reg <= cfg_data[FMAP_W-1:0];
                CFG_STEP_X: step_x_reg <= cfg_data;
                CFG_STEP_Y: step_y_reg <= cfg_data;
                CFG_OFFSET: coff_reg   <= cfg_data[15:0];
                CFG_FLIP:   flip_reg   <= cfg_data[0];
                CFG_CLIP:   clip_reg   <= cfg_data[0];
                default:    fmap_w_reg <= fmap_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            k_reg         <= '0;
            e_reg         <= '0;
            nonone_reg    <= '0;
            nbox_reg      <= CNT_W'(1);
            ci_reg        <= '0;
            single_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            a_sqrt_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            e_reg         <= e_next;
            nonone_reg    <= nonone_next;
            nbox_reg      <= nbox_next;
            ci_reg        <= ci_next;
            single_reg    <= single_next;
            out_valid_reg <= out_valid_next;
            a_sqrt_reg    <= a_sqrt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg   <= raw_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        hm_reg    <= hm_next;
        stat_reg  <= stat_next;
        neg_reg   <= neg_next;
        bw_reg    <= bw_next;
        bh_reg    <= bh_next;
        csx_reg   <= csx_next;
        csy_reg   <= csy_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        m2_reg    <= m2_next;
        a_num_reg <= a_num_next;
        a_den_reg <= a_den_next;
        crd_reg   <= crd_next;
        xl_reg    <= xl_next;
        yl_reg    <= yl_next;
        xh_reg    <= xh_next;
        yh_reg    <= yh_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
        if (mem_we)
        begin
            ratio_mem_reg[mem_wa] <= mem_wd;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign x_low     = xl_reg;
    assign y_low     = yl_reg;
    assign x_high    = xh_reg;
    assign y_high    = yh_reg;
    assign status    = ost_reg;
    assign last      = olast_reg;

endmodule

[src/anc_arith.sv]
// Shared multi-cycle divide / square root unit, one bit per cycle.
// Depends on anc_pkg for widths and the command and status structs.
module anc_arith import anc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  arith_cmd_t         cmd,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output arith_stat_t        stat,
    output logic [NUM_W-1:0]   quo,
    output logic [ROOT_W-1:0]  root
);

    logic              busy_reg, busy_next;
    logic              sqrt_reg, sqrt_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [NUM_W-1:0]  nq_reg, nq_next;
    logic [NUM_W-1:0]  sx_reg, sx_next;
    logic [NUM_W-1:0]  sres_reg, sres_next;
    logic [NUM_W-1:0]  sbit_reg, sbit_next;

    logic [DEN_W:0]    rem_sh;
    logic              div_ge;
    logic [DEN_W:0]    rem_sub;
    logic [NUM_W-1:0]  sq_t;
    logic              sq_ge;

    always_comb
    begin
        rem_sh  = {rem_reg, nq_reg[NUM_W-1]};
        div_ge  = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        sq_t    = sres_reg + sbit_reg;
        sq_ge   = sx_reg >= sq_t;

        busy_next  = busy_reg;
        sqrt_next  = sqrt_reg;
        done_next  = 1'b0;
        steps_next = steps_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        nq_next    = nq_reg;
        sx_next    = sx_reg;
        sres_next  = sres_reg;
        sbit_next  = sbit_reg;

        if (cmd.go)
        begin
            busy_next = 1'b1;
            sqrt_next = cmd.sqrt;
            if (cmd.sqrt)
            begin
                steps_next = STEP_W'(NUM_W / 2);
                sx_next    = num;
                sres_next  = '0;
                sbit_next  = NUM_W'(1) << (NUM_W - 2);
            end
            else
            begin
                steps_next = STEP_W'(NUM_W);
                rem_next   = '0;
                den_next   = den;
                nq_next    = num;
            end
        end
        else if (busy_reg)
        begin
            steps_next = steps_reg - STEP_W'(1);
            if (steps_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (sqrt_reg)
            begin
                // Classic digit-by-digit root: one result bit per step.
                if (sq_ge)
                begin
                    sx_next   = sx_reg - sq_t;
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            else
            begin
                rem_next = div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                nq_next  = {nq_reg[NUM_W-2:0], div_ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sqrt_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sqrt_reg  <= sqrt_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        nq_reg   <= nq_next;
        sx_reg   <= sx_next;
        sres_reg <= sres_next;
        sbit_reg <= sbit_next;
    end

    assign stat.done   = done_reg;
    assign stat.rem_nz = rem_reg != '0;
    assign quo         = nq_reg;
    assign root        = sres_reg[ROOT_W-1:0];

endmodule

[src/anc_checker.sv]
// Port-level checks for anchor_box_generator, attached by the bind below.
// Depends on anc_pkg for the opcode and status codes.
module anc_checker import anc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         op,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [20:0] x_low,
    input logic signed [20:0] y_low,
    input logic signed [20:0] x_high,
    input logic signed [20:0] y_high,
    input logic [1:0]         status,
    input logic               last
);

    // A held result word keeps its x_low, status and last.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_low) && $stable(status)
            && $stable(last))
        else $error("result word changed while stalled");

    // Any error ends the item at once.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("error result not marked last");

    // Error words carry no box.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> x_low == '0 && y_low == '0
            && x_high == '0 && y_high == '0)
        else $error("error result with nonzero corners");

    // A real command keeps the block busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op != OP_NONE |=> in_stall)
        else $error("block took a command without going busy");

endmodule

bind anchor_box_generator anc_checker u_anc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_low     (x_low),
    .y_low     (y_low),
    .x_high    (x_high),
    .y_high    (y_high),
    .status    (status),
    .last      (last)
);
